>>> design/smsprng_pkg.sv
`timescale 1ns / 1ps

package smsprng_pkg;

   localparam int VALUE_W      = 31;
   localparam int MULT_W       = 15;
   localparam int PROD_W       = VALUE_W + MULT_W;
   localparam int TABLE_SIZE   = 32;
   localparam int TABLE_AW     = $clog2(TABLE_SIZE);
   localparam int WARMUP_STEPS = 8;
   localparam int STEP_TOTAL   = WARMUP_STEPS + TABLE_SIZE;
   localparam int CNT_W        = $clog2(STEP_TOTAL);
   // slot divisor is 1 + (2^31-2)/TABLE_SIZE, a power of two for this table size
   localparam int SLOT_LSB     = VALUE_W - TABLE_AW;

   localparam logic [MULT_W-1:0]  LCG_MULT = MULT_W'(16807);
   localparam logic [VALUE_W-1:0] LCG_MOD  = {VALUE_W{1'b1}};
   localparam logic [VALUE_W-1:0] SEED_ONE = VALUE_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP_MUL,
      ST_STEP_RED,
      ST_DRAW_MUL,
      ST_DRAW_RED
   } state_type;

   typedef struct packed {
      logic                load_seed;
      logic                mul;
      logic                reduce;
      logic                fill_we;
      logic                fill_last;
      logic                draw_rd;
      logic                draw_done;
      logic [TABLE_AW-1:0] fill_addr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_zero;
   } dp_status_type;

   // p mod (2^31-1) for p < 2^46: fold the high bits onto the low bits once
   function automatic logic [VALUE_W-1:0] lcg_reduce(input logic [PROD_W-1:0] p);
      logic [VALUE_W:0] sum;
      sum = {1'b0, p[VALUE_W-1:0]} + (VALUE_W + 1)'(p[PROD_W-1:VALUE_W]);
      if (sum >= {1'b0, LCG_MOD}) begin
         sum = sum - {1'b0, LCG_MOD};
      end
      return sum[VALUE_W-1:0];
   endfunction

endpackage

>>> design/smsprng_ram.sv
`timescale 1ns / 1ps

module smsprng_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/smsprng_ctrl.sv
`timescale 1ns / 1ps

module smsprng_ctrl
   import smsprng_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_command,
   input  dp_status_type status,
   output logic          busy,
   output ctrl_cmd_type  cmd
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              need_reseed;

   assign need_reseed = req_command | status.last_zero;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = need_reseed ? ST_STEP_MUL : ST_DRAW_MUL;
            end
         end
         ST_STEP_MUL: state_in = ST_STEP_RED;
         ST_STEP_RED: state_in = (cnt_ff == '0) ? ST_DRAW_MUL : ST_STEP_MUL;
         ST_DRAW_MUL: state_in = ST_DRAW_RED;
         ST_DRAW_RED: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_IDLE && start && need_reseed) begin
         cnt_in = CNT_W'(STEP_TOTAL - 1);
      end else if (state_ff == ST_STEP_RED && cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.fill_addr = cnt_ff[TABLE_AW-1:0];
      busy          = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy          = 1'b0;
            cmd.load_seed = start & need_reseed;
         end
         ST_STEP_MUL: cmd.mul = 1'b1;
         ST_STEP_RED: begin
            cmd.reduce    = 1'b1;
            // counter runs down; the last TABLE_SIZE steps fill from the top entry
            cmd.fill_we   = (cnt_ff < CNT_W'(TABLE_SIZE));
            cmd.fill_last = (cnt_ff == '0);
         end
         ST_DRAW_MUL: begin
            cmd.mul     = 1'b1;
            cmd.draw_rd = 1'b1;
         end
         ST_DRAW_RED: begin
            cmd.reduce    = 1'b1;
            cmd.draw_done = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_step_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP_MUL |=> state_ff == ST_STEP_RED)
      else $error("step multiply not followed by reduce");

   a_draw_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAW_MUL |=> state_ff == ST_DRAW_RED)
      else $error("draw multiply not followed by reduce");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP_MUL || state_ff == ST_STEP_RED)
         |-> cnt_ff <= CNT_W'(STEP_TOTAL - 1))
      else $error("reseed step counter out of range");
`endif

endmodule

>>> design/smsprng_dpath.sv
`timescale 1ns / 1ps

module smsprng_dpath
   import smsprng_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_command,
   input  logic [VALUE_W-1:0]  req_seed_value,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   output logic                rsp_valid,
   output logic [VALUE_W-1:0]  rsp_random_value,
   output logic [VALUE_W-1:0]  rsp_seed_after
);

   logic [VALUE_W-1:0]  seed_ff, seed_in;
   logic [VALUE_W-1:0]  last_ff, last_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_random_ff, rsp_random_in;
   logic [VALUE_W-1:0]  rsp_seed_ff, rsp_seed_in;
   logic [VALUE_W-1:0]  seed_src, load_val, red_val;
   logic [TABLE_AW-1:0] slot;
   logic                ram_we;
   logic [TABLE_AW-1:0] ram_waddr;
   logic [VALUE_W-1:0]  ram_rd_data;

   assign slot    = last_ff[VALUE_W-1:SLOT_LSB];
   assign red_val = lcg_reduce(prod_ff);

   always_comb begin
      seed_src = req_command ? req_seed_value : SEED_ONE;
      // zero and the modulus itself would lock the generator at zero
      load_val = (seed_src == '0 || seed_src == LCG_MOD) ? SEED_ONE : seed_src;
   end

   always_comb begin
      seed_in = seed_ff;
      if (cmd.load_seed) begin
         seed_in = load_val;
      end else if (cmd.reduce) begin
         seed_in = red_val;
      end
   end

   always_comb begin
      last_in = last_ff;
      if (cmd.fill_last) begin
         last_in = red_val;
      end else if (cmd.draw_done) begin
         last_in = ram_rd_data;
      end
   end

   always_comb begin
      prod_in = prod_ff;
      if (cmd.mul) begin
         prod_in = PROD_W'(seed_ff) * PROD_W'(LCG_MULT);
      end
      rsp_random_in = cmd.draw_done ? ram_rd_data : rsp_random_ff;
      rsp_seed_in   = cmd.draw_done ? red_val : rsp_seed_ff;
   end

   assign ram_we    = cmd.fill_we | cmd.draw_done;
   assign ram_waddr = cmd.draw_done ? slot : cmd.fill_addr;

   smsprng_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (red_val),
      .rd_en   (cmd.draw_rd),
      .rd_addr (slot),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SEED_ONE;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         last_ff      <= last_in;
         rsp_valid_ff <= cmd.draw_done;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      rsp_random_ff <= rsp_random_in;
      rsp_seed_ff   <= rsp_seed_in;
   end

   assign status.last_zero = (last_ff == '0);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_random_ff;
   assign rsp_seed_after   = rsp_seed_ff;

`ifndef SYNTHESIS
   a_seed_nonzero: assert property (@(posedge clock) disable iff (reset)
      seed_ff != '0)
      else $error("generator seed reached zero");

   a_draw_table_full: assert property (@(posedge clock) disable iff (reset)
      cmd.draw_done |-> last_ff != '0)
      else $error("draw from an empty table");

   a_no_write_conflict: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fill_we && cmd.draw_done))
      else $error("fill and draw write in the same cycle");
`endif

endmodule

>>> design/shuffled_minimal_standard_prng.sv
`timescale 1ns / 1ps
// Draw: busy from start through the multiply, then mod-reduce plus table swap;
//   rsp_valid pulses in the first cycle with busy low; start is taken only in idle.
// Reseed (or first draw after reset): 40 LCG steps, each a multiply then a reduce,
//   then the draw; busy stays high. The single 31x15 multiplier sets the step time.
// Reset: seed 1, table empty; the table needs no clearing since it is filled before use.
// rsp_valid is a one-cycle strobe; the receiver cannot stall.

module shuffled_minimal_standard_prng
   import smsprng_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [VALUE_W-1:0] req_seed_value,
   output logic               rsp_valid,
   output logic [VALUE_W-1:0] rsp_random_value,
   output logic [VALUE_W-1:0] rsp_seed_after
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   smsprng_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .status      (status),
      .busy        (busy),
      .cmd         (cmd)
   );

   smsprng_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_seed_value   (req_seed_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_random_value (rsp_random_value),
      .rsp_seed_after   (rsp_seed_after)
   );

endmodule
